@@ hw/rtl/pfb_pkg.sv @@
// Package for the planar framebuffer span engine: geometry constants,
// request kinds, status codes and register indexes. No dependencies.
package pfb_pkg;
  localparam int ScreenWidth  = 320;
  localparam int ScreenHeight = 200;
  localparam int MaxPlanes    = 8;
  localparam int Pixels       = ScreenWidth * ScreenHeight;
  localparam int Groups       = (Pixels + 15) / 16;
  localparam int Depth        = Groups * MaxPlanes;
  localparam int AddrW        = $clog2(Depth);
  localparam int PixW         = $clog2(Pixels + 1) + 1;

  localparam logic [1:0] KIND_READ  = 2'd0;
  localparam logic [1:0] KIND_WRITE = 2'd1;
  localparam logic [1:0] KIND_SPAN  = 2'd2;

  localparam logic [1:0] ST_DONE   = 2'd0;
  localparam logic [1:0] ST_OUTSCR = 2'd1;
  localparam logic [1:0] ST_YCLIP  = 2'd2;

  localparam logic [2:0] REG_PLANES = 3'd0;
  localparam logic [2:0] REG_XMIN   = 3'd1;
  localparam logic [2:0] REG_XMAX   = 3'd2;
  localparam logic [2:0] REG_YMIN   = 3'd3;
  localparam logic [2:0] REG_YMAX   = 3'd4;
endpackage

@@ hw/rtl/planar_framebuffer_pixel_span_engine_unit.sv @@
// Planar framebuffer pixel span engine: read, write and fill-span search.
// Each request walks the n = planes used plane words of a pixel through one memory port,
// one plane word at a time; off-screen reads and writes, off-screen span probes, clipped
// spans and unused kinds skip the store. A span probes to the right of the start, then to
// the left, up to 2048 probes. One request at a time; the next may be taken while the last
// result waits. After synchronous reset the store is cleared before the first request.
module planar_framebuffer_pixel_span_engine_unit
  import pfb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // kind[1:0], pos_x[12:2], pos_y[23:13], pixel_value[31:24],
  // match_color[39:32], seed_pol[40], zeros[47:41]
  input  logic [47:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // read_color[7:0], span_left[18:8], span_right[29:19], span_flag[30],
  // status[32:31], zeros[39:33]
  output logic [39:0] out_tdata,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  typedef enum logic [9:0] {
    S_CLEAR = 10'b0000000001, S_IDLE  = 10'b0000000010,
    S_PIX   = 10'b0000000100, S_RD    = 10'b0000001000,
    S_RDW   = 10'b0000010000, S_WRB   = 10'b0000100000,
    S_NEXT  = 10'b0001000000, S_OUT   = 10'b0010000000,
    S_CHK   = 10'b0100000000, S_PRE   = 10'b1000000000
  } state_t;

  state_t state_r;
  logic [3:0]  planes_r;
  logic [9:0]  xmin_r, xmax_r, ymin_r, ymax_r;
  logic [1:0]  kind_r;
  logic signed [10:0] y_r, cx_r, left_r, right_r;
  logic [7:0]  val_r, search_r, color_r, acc_r;
  logic        seed_r, dir_r, first_r;
  logic [3:0]  k_r;
  logic [AddrW-1:0] clr_r;
  logic [39:0] res_r;
  logic [39:0] out_r;
  logic        outv_r;
  // On-screen flag of the start pixel, kept for the span status.
  logic        onscr_r0;

  // Plane count clamp.
  logic [3:0] n_used;
  always_comb begin
    if (planes_r == 4'd0) n_used = 4'd1;
    else if (planes_r > 4'(MaxPlanes)) n_used = 4'(MaxPlanes);
    else n_used = planes_r;
  end

  // Pixel index of the current probe x on row y.
  logic signed [PixW+12:0] p_s;
  logic on_scr;
  logic [PixW-1:0] p_u;
  logic [AddrW-1:0] base;
  logic [3:0] bitpos;
  assign p_s = (PixW+13)'(y_r) * (PixW+13)'(ScreenWidth) + (PixW+13)'(cx_r);
  assign on_scr = (p_s >= 0) && (p_s < (PixW+13)'(Pixels));
  assign p_u = p_s[PixW-1:0];
  assign bitpos = p_u[3:0];

  logic [AddrW-1:0] base_r;
  logic [3:0]  bit_r;
  assign base = AddrW'((p_u >> 4) * n_used);

  // Memory.
  logic we;
  logic [AddrW-1:0] addr;
  logic [15:0] wdata, rdata;
  pfb_ram #(.Width(16), .Depth(Depth)) u_ram (
    .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
  );

  logic [15:0] mask;
  assign mask = 16'h8000 >> bit_r;

  always_comb begin
    we = 1'b0;
    addr = base_r + AddrW'(k_r);
    wdata = val_r[k_r[2:0]] ? (rdata | mask) : (rdata & ~mask);
    if (state_r == S_CLEAR) begin
      we = 1'b1; addr = clr_r; wdata = '0;
    end else if (state_r == S_WRB) begin
      we = 1'b1;
    end
  end

  logic cfg_wr;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;
  always_comb begin
    case (cfg_paddr[4:2])
      REG_PLANES: cfg_prdata = {28'd0, planes_r};
      REG_XMIN:   cfg_prdata = {22'd0, xmin_r};
      REG_XMAX:   cfg_prdata = {22'd0, xmax_r};
      REG_YMIN:   cfg_prdata = {22'd0, ymin_r};
      REG_YMAX:   cfg_prdata = {22'd0, ymax_r};
      default:    cfg_prdata = '0;
    endcase
  end

  // The finished result sits in res_r until the output register is free, and no new
  // request is taken meanwhile; a result waiting in the output register does not block one.
  assign in_tready = (state_r == S_IDLE);
  assign out_tvalid = outv_r;
  assign out_tdata = out_r;

  logic [7:0] acc_nxt;
  assign acc_nxt = acc_r | (rdata[4'd15 - bit_r] ? (8'd1 << k_r[2:0]) : 8'd0);

  logic signed [11:0] ext_xmin, ext_xmax;
  assign ext_xmin = 12'(xmin_r);
  assign ext_xmax = 12'(xmax_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR; clr_r <= '0; outv_r <= 1'b0;
      planes_r <= 4'd4; xmin_r <= 10'd0; xmax_r <= 10'd319;
      ymin_r <= 10'd0; ymax_r <= 10'd199;
    end else begin
      if (cfg_wr) begin
        case (cfg_paddr[4:2])
          REG_PLANES: planes_r <= cfg_pwdata[3:0];
          REG_XMIN:   xmin_r <= cfg_pwdata[9:0];
          REG_XMAX:   xmax_r <= cfg_pwdata[9:0];
          REG_YMIN:   ymin_r <= cfg_pwdata[9:0];
          REG_YMAX:   ymax_r <= cfg_pwdata[9:0];
          default: ;
        endcase
      end
      if (outv_r && out_tready) outv_r <= 1'b0;
      case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == AddrW'(Depth - 1)) state_r <= S_IDLE;
        end
        S_IDLE: if (in_tvalid && in_tready) begin
          kind_r <= in_tdata[1:0];
          cx_r <= in_tdata[12:2];
          y_r <= in_tdata[23:13];
          val_r <= in_tdata[31:24]; search_r <= in_tdata[39:32];
          seed_r <= in_tdata[40];
          left_r <= in_tdata[12:2]; right_r <= in_tdata[12:2];
          first_r <= 1'b1; dir_r <= 1'b0;
          state_r <= S_PRE;
        end
        S_PRE: begin
          if (kind_r == KIND_SPAN &&
              (y_r < $signed(12'(ymin_r)) || y_r > $signed(12'(ymax_r)))) begin
            res_r <= {7'd0, ST_YCLIP, 31'd0}; state_r <= S_OUT;
          end else if (kind_r == KIND_READ || kind_r == KIND_WRITE ||
                       kind_r == KIND_SPAN) begin
            state_r <= S_PIX;
          end else begin
            res_r <= '0; state_r <= S_OUT;
          end
        end
        S_PIX: begin
          // Latch address of current probe pixel, start plane walk.
          base_r <= base; bit_r <= bitpos;
          k_r <= '0; acc_r <= '0;
          if (!on_scr) begin
            if (kind_r == KIND_SPAN) state_r <= S_CHK;
            else begin
              res_r <= {7'd0, ST_OUTSCR, 31'd0}; state_r <= S_OUT;
            end
          end else state_r <= S_RD;
        end
        S_RD: state_r <= S_RDW;
        S_RDW: begin
          if (kind_r == KIND_WRITE) state_r <= S_WRB;
          else begin
            acc_r <= acc_nxt;
            if (k_r + 1'b1 == n_used) state_r <= S_CHK;
            else begin k_r <= k_r + 1'b1; state_r <= S_RD; end
          end
        end
        S_WRB: begin
          if (k_r + 1'b1 == n_used) begin
            res_r <= '0; state_r <= S_OUT;
          end else begin k_r <= k_r + 1'b1; state_r <= S_RD; end
        end
        S_CHK: begin
          // A mismatch on the right side is handled in S_NEXT, which turns
          // the walk to the left; a mismatch on the left side ends the span.
          if (kind_r == KIND_READ) begin
            res_r <= {7'd0, ST_DONE, 23'd0, acc_r}; state_r <= S_OUT;
          end else if (first_r) begin
            first_r <= 1'b0; color_r <= acc_r; state_r <= S_NEXT;
          end else if (acc_r == color_r) begin
            if (dir_r) left_r <= cx_r; else right_r <= cx_r;
            state_r <= S_NEXT;
          end else if (dir_r) begin
            res_r <= {7'd0, onscr_r0 ? ST_DONE : ST_OUTSCR,
                      seed_r ^ (color_r != search_r), right_r, left_r, color_r};
            state_r <= S_OUT;
          end else begin
            state_r <= S_NEXT;
          end
        end
        S_NEXT: begin
          // Choose next probe x or finish.
          if (!dir_r && (12'(right_r) < ext_xmax) &&
              !(!first_r && cx_r != right_r)) begin
            cx_r <= right_r + 11'sd1; state_r <= S_PIX;
          end else if (!dir_r) begin
            dir_r <= 1'b1;
            if (12'(left_r) > ext_xmin) begin
              cx_r <= left_r - 11'sd1; state_r <= S_PIX;
            end else begin
              res_r <= {7'd0, onscr_r0 ? ST_DONE : ST_OUTSCR,
                        seed_r ^ (color_r != search_r), right_r, left_r, color_r};
              state_r <= S_OUT;
            end
          end else if ((12'(left_r) > ext_xmin) && cx_r == left_r) begin
            cx_r <= left_r - 11'sd1; state_r <= S_PIX;
          end else begin
            res_r <= {7'd0, onscr_r0 ? ST_DONE : ST_OUTSCR,
                      seed_r ^ (color_r != search_r), right_r, left_r, color_r};
            state_r <= S_OUT;
          end
        end
        S_OUT: if (!outv_r) begin
          out_r <= res_r; outv_r <= 1'b1; state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_PIX && first_r) onscr_r0 <= on_scr;
  end
endmodule

@@ hw/rtl/pfb_ram.sv @@
// Generic single-port synchronous RAM with registered read data.
// Depends on nothing.
module pfb_ram #(
  parameter int Width = 16,
  parameter int Depth = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

@@ dv/tb.sv @@
// Self-checking testbench for the planar framebuffer pixel span engine.
// Drives read, write and span requests, predicts every result from a local
// model of the plane store and registers. Depends on pfb_pkg and the unit.
`timescale 1ns / 1ps
module tb;
  import pfb_pkg::*;

  localparam logic [1:0] KindUnused = 2'd3;

  typedef struct packed {
    logic [6:0]  pad;
    logic        seed_pol;
    logic [7:0]  match_color;
    logic [7:0]  pixel_value;
    logic [10:0] pos_y;
    logic [10:0] pos_x;
    logic [1:0]  kind;
  } req_t;

  typedef struct packed {
    logic [6:0]  pad;
    logic [1:0]  status;
    logic        span_flag;
    logic [10:0] span_right;
    logic [10:0] span_left;
    logic [7:0]  read_color;
  } rsp_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [47:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic cfg_psel = 1'b0, cfg_penable = 1'b0, cfg_pwrite = 1'b0;
  logic [4:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  planar_framebuffer_pixel_span_engine_unit dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the register settings.
  int unsigned planes_reg;
  int xmin_reg, xmax_reg, ymin_reg, ymax_reg;

  req_t pending_reqs[$];
  rsp_t expected_rsps[$];
  int errors = 0;
  int cycle = 0;
  int burst_left = 0, gap_left = 0;
  bit hold_sender = 1'b0;

  function automatic int unsigned used_planes();
    if (planes_reg == 0) return 1;
    if (planes_reg > MaxPlanes) return MaxPlanes;
    return planes_reg;
  endfunction

  // A pixel's color as the engine composes it from the current plane count.
  // Words written at a different plane count alias into other pixels,
  // so the shadow stores the raw planes instead of colors.
  logic [15:0] plane_words [Depth];

  function automatic logic [7:0] pixel_color(int p);
    int unsigned n, base;
    logic [7:0] c;
    c = '0;
    if (p < 0 || p >= Pixels) return 8'd0;
    n = used_planes();
    base = (p >> 4) * n;
    for (int k = 0; k < n; k++)
      c[k] = plane_words[base + k][15 - (p & 15)];
    return c;
  endfunction

  // Works out the result of one request and updates the shadow store.
  function automatic rsp_t predict_pixel_op(req_t r);
    rsp_t o;
    int x, y, p, lft, rgt;
    int unsigned n, base;
    o = '0;
    x = $signed(r.pos_x);
    y = $signed(r.pos_y);
    p = y * ScreenWidth + x;
    case (r.kind)
      KIND_READ: begin
        if (p >= 0 && p < Pixels) o.read_color = pixel_color(p);
        else o.status = ST_OUTSCR;
      end
      KIND_WRITE: begin
        if (p >= 0 && p < Pixels) begin
          n = used_planes();
          base = (p >> 4) * n;
          for (int k = 0; k < n; k++)
            plane_words[base + k][15 - (p & 15)] = r.pixel_value[k];
        end else begin
          o.status = ST_OUTSCR;
        end
      end
      KIND_SPAN: begin
        if (y < ymin_reg || y > ymax_reg) begin
          o.status = ST_YCLIP;
        end else begin
          o.read_color = pixel_color(p);
          if (p < 0 || p >= Pixels) o.status = ST_OUTSCR;
          rgt = x;
          while (rgt < xmax_reg && pixel_color(y * ScreenWidth + rgt + 1) == o.read_color)
            rgt++;
          lft = x;
          while (lft > xmin_reg && pixel_color(y * ScreenWidth + lft - 1) == o.read_color)
            lft--;
          o.span_left = lft[10:0];
          o.span_right = rgt[10:0];
          o.span_flag = r.seed_pol ^ (o.read_color != r.match_color);
        end
      end
      default: ;
    endcase
    return o;
  endfunction

  // Driver: bursts of requests separated by random gaps.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        expected_rsps.push_back(predict_pixel_op(req_t'(in_tdata)));
        void'(pending_reqs.pop_front());
      end
      if (gap_left > 0) gap_left <= gap_left - 1;
      if (hold_sender || (gap_left > 0) ||
          (in_tvalid && in_tready && pending_reqs.size() == 0) ||
          (!in_tvalid && pending_reqs.size() == 0)) begin
        if (!(in_tvalid && !in_tready)) in_tvalid <= 1'b0;
      end else if (!(in_tvalid && !in_tready)) begin
        // Request the queue front; a new burst or gap starts when this one ends.
        if (in_tvalid && in_tready && burst_left <= 0) begin
          in_tvalid <= 1'b0;
          gap_left <= $urandom_range(1, 6);
          burst_left <= $urandom_range(0, 8);
        end else begin
          in_tvalid <= 1'b1;
          in_tdata <= pending_reqs[0];
          if (in_tvalid && in_tready) burst_left <= burst_left - 1;
        end
      end
    end
  end

  // Monitor: receiver stalls on a periodic-plus-random pattern.
  always @(posedge clk) begin
    cycle <= cycle + 1;
    out_tready <= ((cycle % 37) > 20) ? 1'b1 : ($urandom_range(0, 2) != 0);
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_rsps.size() == 0) begin
        $error("unexpected result %h", out_tdata);
        errors = errors + 1;
      end else begin
        rsp_t e, a;
        e = expected_rsps.pop_front();
        a = rsp_t'(out_tdata);
        if (a.read_color !== e.read_color) begin
          $error("read_color exp %h got %h", e.read_color, a.read_color); errors = errors + 1;
        end
        if (a.span_left !== e.span_left) begin
          $error("span_left exp %0d got %0d", $signed(e.span_left), $signed(a.span_left));
          errors = errors + 1;
        end
        if (a.span_right !== e.span_right) begin
          $error("span_right exp %0d got %0d", $signed(e.span_right), $signed(a.span_right));
          errors = errors + 1;
        end
        if (a.span_flag !== e.span_flag) begin
          $error("span_flag exp %b got %b", e.span_flag, a.span_flag); errors = errors + 1;
        end
        if (a.status !== e.status) begin
          $error("status exp %0d got %0d", e.status, a.status); errors = errors + 1;
        end
      end
    end
    if (cycle > 10000000) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic write_reg(logic [2:0] idx, int unsigned val);
    @(posedge clk);
    cfg_psel <= 1'b1; cfg_pwrite <= 1'b1; cfg_penable <= 1'b0;
    cfg_paddr <= {idx, 2'b00}; cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
    case (idx)
      REG_PLANES: planes_reg = val & 4'hf;
      REG_XMIN:   xmin_reg = val & 10'h3ff;
      REG_XMAX:   xmax_reg = val & 10'h3ff;
      REG_YMIN:   ymin_reg = val & 10'h3ff;
      default:    ymax_reg = val & 10'h3ff;
    endcase
  endtask

  // Waits until every queued request has been taken and answered.
  task automatic drain();
    while (pending_reqs.size() != 0 || in_tvalid || expected_rsps.size() != 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic req_t make_req(logic [1:0] k, int x, int y, int v, int s, int sd);
    req_t r;
    r = '0;
    r.kind = k; r.pos_x = x[10:0]; r.pos_y = y[10:0];
    r.pixel_value = v[7:0]; r.match_color = s[7:0]; r.seed_pol = sd[0];
    return r;
  endfunction

  // Mostly coordinates with x in -5..325 and y in -1..11, sometimes anywhere.
  task automatic random_phase(int count);
    int x, y;
    for (int i = 0; i < count; i++) begin
      x = $urandom_range(0, 9) == 0 ? $urandom_range(0, 2047) - 1024 : $urandom_range(0, 330) - 5;
      y = $urandom_range(0, 9) == 0 ? $urandom_range(0, 2047) - 1024 : $urandom_range(0, 12) - 1;
      pending_reqs.push_back(make_req(
        $urandom_range(0, 3) == 3 ? KindUnused : 2'($urandom_range(0, 2)),
        x, y, $urandom_range(0, 3) == 0 ? $urandom_range(0, 255) : $urandom_range(0, 1),
        $urandom_range(0, 255) & ($urandom_range(0, 1) ? 8'hff : 8'h01),
        $urandom_range(0, 1)));
    end
  endtask

  initial begin
    foreach (plane_words[i]) plane_words[i] = '0;
    planes_reg = 4; xmin_reg = 0; xmax_reg = 319; ymin_reg = 0; ymax_reg = 199;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: extremes, every kind, screen end, clip and unused kind.
    pending_reqs.push_back(make_req(KIND_WRITE, 0, 0, 255, 0, 0));
    pending_reqs.push_back(make_req(KIND_WRITE, 319, 199, 15, 0, 0));
    pending_reqs.push_back(make_req(KIND_WRITE, 0, 200, 5, 0, 0));
    pending_reqs.push_back(make_req(KIND_WRITE, -1, 0, 5, 0, 0));
    pending_reqs.push_back(make_req(KIND_WRITE, 1023, 1023, 255, 0, 0));
    pending_reqs.push_back(make_req(KIND_WRITE, 320, 0, 9, 0, 0));
    pending_reqs.push_back(make_req(KIND_READ, 0, 0, 0, 0, 0));
    pending_reqs.push_back(make_req(KIND_READ, 319, 199, 0, 0, 0));
    pending_reqs.push_back(make_req(KIND_READ, 0, 1, 0, 0, 0));
    pending_reqs.push_back(make_req(KIND_READ, -1024, -1024, 0, 0, 0));
    pending_reqs.push_back(make_req(KIND_READ, 0, 200, 0, 0, 0));
    pending_reqs.push_back(make_req(KIND_SPAN, 5, 0, 0, 0, 0));
    pending_reqs.push_back(make_req(KIND_SPAN, 0, 0, 0, 255, 1));
    pending_reqs.push_back(make_req(KIND_SPAN, 10, 200, 0, 0, 1));
    pending_reqs.push_back(make_req(KIND_SPAN, 10, -1, 0, 0, 0));
    pending_reqs.push_back(make_req(KIND_SPAN, 1023, 199, 0, 0, 1));
    pending_reqs.push_back(make_req(KIND_SPAN, -1024, 1, 0, 0, 0));
    pending_reqs.push_back(make_req(KindUnused, 1023, 1023, 255, 255, 1));
    drain();

    // Sender holds off while random requests are queued, then lets them out.
    hold_sender = 1'b1;
    random_phase(100);
    repeat (50) @(posedge clk);
    hold_sender = 1'b0;
    drain();

    write_reg(REG_PLANES, 1); write_reg(REG_XMIN, 3); write_reg(REG_XMAX, 40);
    write_reg(REG_YMIN, 1); write_reg(REG_YMAX, 8);
    pending_reqs.push_back(make_req(KIND_SPAN, 1, 2, 0, 0, 0));
    pending_reqs.push_back(make_req(KIND_SPAN, 100, 2, 0, 0, 0));
    random_phase(100);
    drain();

    write_reg(REG_PLANES, 8); write_reg(REG_XMIN, 1023); write_reg(REG_XMAX, 0);
    write_reg(REG_YMIN, 1023); write_reg(REG_YMAX, 1023);
    random_phase(30);
    drain();

    write_reg(REG_PLANES, 0); write_reg(REG_XMIN, 0); write_reg(REG_XMAX, 1023);
    write_reg(REG_YMIN, 0); write_reg(REG_YMAX, 1023);
    random_phase(50);
    drain();

    write_reg(REG_PLANES, 15); write_reg(REG_XMAX, 319); write_reg(REG_YMAX, 199);
    random_phase(60);
    drain();

    write_reg(REG_PLANES, 3);
    random_phase(60);
    drain();

    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
